### hdl/slotalloc_pkg.sv
// ----------------------------------------------------------------------------
// slotalloc_pkg
// shared constants for the slot allocator: rack size, widths, codes
// ----------------------------------------------------------------------------
package slotalloc_pkg;

   localparam int NUM_SLOTS = 64;

   localparam int MODE_W  = 2;
   localparam int DATA_W  = 32;
   localparam int SLOT_W  = 12;
   localparam int STAT_W  = 3;
   localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int ENTRY_W = 2 * DATA_W;

   localparam logic [MODE_W-1:0] MODE_STORE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RETRIEVE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
   localparam logic [STAT_W-1:0] ST_RANGE      = 3'd2;
   localparam logic [STAT_W-1:0] ST_FREE       = 3'd3;
   localparam logic [STAT_W-1:0] ST_ZERO_OWNER = 3'd4;

endpackage

### hdl/slotalloc_ram.sv
// ----------------------------------------------------------------------------
// slotalloc_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module slotalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/slot_allocator_with_payload_top.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_payload_top
// rack of slots with a lifo free list; store, query and retrieve requests
// ----------------------------------------------------------------------------
// channel   direction  handshake                 word
// req_      in         req_valid / req_stall     mode, owner_id, belongings, slot_index
// rsp_      out        rsp_valid / rsp_stall     status, slot_out, owner_out,
//                                                payload_out, slot_is_free
//
// one request at a time: the accept edge reads the slot ram and the free stack
// ram; the completing edge writes the rams the request needs and loads the response register.
// synchronous reset empties the response register and refills the free list
// at once through per-entry valid bits; no clearing pass is needed.
// a stalled response holds the request busy until the response register frees.
// ----------------------------------------------------------------------------
module slot_allocator_with_payload_top
   import slotalloc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [DATA_W-1:0] req_owner_id,
   input  logic [DATA_W-1:0] req_belongings,
   input  logic [SLOT_W-1:0] req_slot_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic [SLOT_W-1:0] rsp_slot_out,
   output logic [DATA_W-1:0] rsp_owner_out,
   output logic [DATA_W-1:0] rsp_payload_out,
   output logic              rsp_slot_is_free
);

   logic busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_SLOTS-1:0] own_vld_ff, own_vld_in;
   logic [NUM_SLOTS-1:0] stk_vld_ff, stk_vld_in;

   logic [MODE_W-1:0] mode_ff;
   logic [DATA_W-1:0] owner_ff;
   logic [DATA_W-1:0] pay_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic              range_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0] slot_out_ff, slot_out_in;
   logic [DATA_W-1:0] owner_out_ff, owner_out_in;
   logic [DATA_W-1:0] payload_out_ff, payload_out_in;
   logic              free_ff, free_in;

   logic                accept;
   logic                done;
   logic [CNT_W-1:0]    cnt_dec;
   logic [SLOT_AW-1:0]  top_addr;
   logic [SLOT_AW-1:0]  push_addr;
   logic [SLOT_W-1:0]   stk_rd_data;
   logic [SLOT_W-1:0]   top_slot;
   logic [ENTRY_W-1:0]  ent_rd_data;
   logic [DATA_W-1:0]   held_owner;
   logic [DATA_W-1:0]   held_pay;
   logic [SLOT_AW-1:0]  idx_addr;

   logic                ent_we;
   logic [SLOT_AW-1:0]  ent_wa;
   logic [ENTRY_W-1:0]  ent_wd;
   logic                stk_we;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff;
   assign done      = busy_ff && (!rsp_valid_ff || !rsp_stall);

   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign top_addr  = cnt_dec[SLOT_AW-1:0];
   assign push_addr = cnt_ff[SLOT_AW-1:0];
   assign idx_addr  = idx_ff[SLOT_AW-1:0];

   // unwritten stack entries hold their reset index
   assign top_slot   = stk_vld_ff[top_addr] ? stk_rd_data
                     : SLOT_W'(NUM_SLOTS - 1) - SLOT_W'(top_addr);
   assign held_owner = own_vld_ff[idx_addr] ? ent_rd_data[ENTRY_W-1:DATA_W] : '0;
   assign held_pay   = own_vld_ff[idx_addr] ? ent_rd_data[DATA_W-1:0] : '0;

   slotalloc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_en   (accept),
      .rd_addr (req_slot_index[SLOT_AW-1:0]),
      .rd_data (ent_rd_data)
   );

   slotalloc_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (push_addr),
      .wr_data (idx_ff),
      .rd_en   (accept),
      .rd_addr (top_addr),
      .rd_data (stk_rd_data)
   );

   always_comb begin
      busy_in        = busy_ff;
      cnt_in         = cnt_ff;
      own_vld_in     = own_vld_ff;
      stk_vld_in     = stk_vld_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      status_in      = status_ff;
      slot_out_in    = slot_out_ff;
      owner_out_in   = owner_out_ff;
      payload_out_in = payload_out_ff;
      free_in        = free_ff;
      ent_we         = 1'b0;
      ent_wa         = idx_addr;
      ent_wd         = '0;
      stk_we         = 1'b0;

      if (accept) begin
         busy_in = 1'b1;
      end

      if (done) begin
         busy_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         status_in      = ST_OK;
         slot_out_in    = idx_ff;
         owner_out_in   = '0;
         payload_out_in = '0;
         free_in        = 1'b0;
         if (mode_ff == MODE_STORE) begin
            if (owner_ff == '0) begin
               status_in = ST_ZERO_OWNER;
            end else if (cnt_ff == '0 || cnt_ff > CNT_W'(NUM_SLOTS)) begin
               status_in = ST_FULL;
            end else begin
               cnt_in = cnt_dec;
               if ({1'b0, top_slot} >= (SLOT_W + 1)'(NUM_SLOTS)) begin
                  status_in = ST_FULL;
               end else begin
                  slot_out_in                          = top_slot;
                  ent_we                               = 1'b1;
                  ent_wa                               = top_slot[SLOT_AW-1:0];
                  ent_wd                               = {owner_ff, pay_ff};
                  own_vld_in[top_slot[SLOT_AW-1:0]]    = 1'b1;
               end
            end
         end else if (range_ff) begin
            status_in = ST_RANGE;
         end else if (mode_ff == MODE_RETRIEVE) begin
            free_in = 1'b1;
            if (held_owner == '0) begin
               status_in = ST_FREE;
            end else begin
               owner_out_in         = held_owner;
               payload_out_in       = held_pay;
               ent_we               = 1'b1;
               own_vld_in[idx_addr] = 1'b1;
               if (cnt_ff < CNT_W'(NUM_SLOTS)) begin
                  stk_we                = 1'b1;
                  stk_vld_in[push_addr] = 1'b1;
                  cnt_in                = cnt_ff + CNT_W'(1);
               end
            end
         end else begin
            owner_out_in = held_owner;
            free_in      = (held_owner == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= CNT_W'(NUM_SLOTS);
         own_vld_ff   <= '0;
         stk_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         own_vld_ff   <= own_vld_in;
         stk_vld_ff   <= stk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         owner_ff <= req_owner_id;
         pay_ff   <= req_belongings;
         idx_ff   <= req_slot_index;
         range_ff <= ({1'b0, req_slot_index} >= (SLOT_W + 1)'(NUM_SLOTS));
      end
      status_ff      <= status_in;
      slot_out_ff    <= slot_out_in;
      owner_out_ff   <= owner_out_in;
      payload_out_ff <= payload_out_in;
      free_ff        <= free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot_out     = slot_out_ff;
   assign rsp_owner_out    = owner_out_ff;
   assign rsp_payload_out  = payload_out_ff;
   assign rsp_slot_is_free = free_ff;

endmodule

### sim/tb_slot_allocator_with_payload_top.sv
// ----------------------------------------------------------------------------
// tb_slot_allocator_with_payload_top
// checks stores, queries and retrieves against a cycle-free model of the rack
// ----------------------------------------------------------------------------
// a short directed list covers zero owner, range errors, double retrieve,
// the unused mode and lifo reuse of slots. random traffic then alternates
// fill, drain and mixed episodes so the rack is driven full and empty many
// times. both channels idle in random bursts except in the closing stretch.
// every response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_slot_allocator_with_payload_top;
   import slotalloc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_ITEMS  = 60;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] owner;
      logic [DATA_W-1:0] payload;
      logic              is_free;
   } rack_word_type;

   typedef enum {EP_FILL, EP_DRAIN, EP_MIX} episode_type;

   class rack_scoreboard;
      logic [SLOT_W-1:0] free_stack [NUM_SLOTS];
      int unsigned       free_count;
      logic [DATA_W-1:0] owner_tab [NUM_SLOTS];
      logic [DATA_W-1:0] payload_tab [NUM_SLOTS];
      rack_word_type     awaited_words[$];
      int                mismatches;
      int                words_checked;
      int                mode_hits[4];
      int                status_hits[int'(ST_ZERO_OWNER) + 1];

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            free_stack[i]  = SLOT_W'(NUM_SLOTS - 1 - i);
            owner_tab[i]   = '0;
            payload_tab[i] = '0;
         end
         free_count = NUM_SLOTS;
         mismatches = 0;
         words_checked = 0;
         foreach (mode_hits[i]) mode_hits[i] = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function rack_word_type predict_word(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] owner,
                                           logic [DATA_W-1:0] pay, logic [SLOT_W-1:0] idx);
         rack_word_type     r;
         logic [SLOT_W-1:0] slot;
         logic [DATA_W-1:0] held;
         r = '0;
         r.status = ST_OK;
         r.slot = idx;
         if (mode == MODE_STORE) begin
            if (owner == '0) begin
               r.status = ST_ZERO_OWNER;
            end else if (free_count == 0 || free_count > NUM_SLOTS) begin
               r.status = ST_FULL;
            end else begin
               free_count--;
               slot = free_stack[free_count];
               if (slot >= NUM_SLOTS) begin
                  r.status = ST_FULL;
               end else begin
                  owner_tab[slot] = owner;
                  payload_tab[slot] = pay;
                  r.slot = slot;
               end
            end
         end else if (idx >= NUM_SLOTS) begin
            r.status = ST_RANGE;
         end else if (mode == MODE_RETRIEVE) begin
            held = owner_tab[idx];
            r.is_free = 1'b1;
            if (held == '0) begin
               r.status = ST_FREE;
            end else begin
               r.owner = held;
               r.payload = payload_tab[idx];
               owner_tab[idx] = '0;
               payload_tab[idx] = '0;
               if (free_count < NUM_SLOTS) begin
                  free_stack[free_count] = idx;
                  free_count++;
               end
            end
         end else begin
            // query, and the unused mode behaves the same
            r.owner = owner_tab[idx];
            r.is_free = (owner_tab[idx] == '0);
         end
         return r;
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] owner,
                                 logic [DATA_W-1:0] pay, logic [SLOT_W-1:0] idx);
         rack_word_type w;
         mode_hits[mode]++;
         w = predict_word(mode, owner, pay, idx);
         awaited_words.insert(awaited_words.size(), w);
      endfunction

      function int held_slot();
         int held[$];
         for (int i = 0; i < NUM_SLOTS; i++)
            if (owner_tab[i] != '0) held.insert(held.size(), i);
         if (held.size() == 0) return -1;
         return held[$urandom_range(0, held.size() - 1)];
      endfunction

      task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t word %0d: %0s got %0h expected %0h",
                     $time, words_checked, what, got, want);
      endtask

      task check_word(rack_word_type got);
         rack_word_type want;
         words_checked++;
         if (awaited_words.size() == 0) begin
            report("unrequested word, status", got.status, '0);
            return;
         end
         want = awaited_words[0];
         awaited_words.delete(0);
         if (want.status <= ST_ZERO_OWNER) status_hits[want.status]++;
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.slot !== want.slot) report("slot_out", got.slot, want.slot);
         if (got.owner !== want.owner) report("owner_out", got.owner, want.owner);
         if (got.payload !== want.payload) report("payload_out", got.payload, want.payload);
         if (got.is_free !== want.is_free) report("slot_is_free", got.is_free, want.is_free);
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [MODE_W-1:0] req_mode = MODE_QUERY;
   logic [DATA_W-1:0] req_owner_id = '0;
   logic [DATA_W-1:0] req_belongings = '0;
   logic [SLOT_W-1:0] req_slot_index = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [SLOT_W-1:0] rsp_slot_out;
   logic [DATA_W-1:0] rsp_owner_out;
   logic [DATA_W-1:0] rsp_payload_out;
   logic              rsp_slot_is_free;

   rack_scoreboard board = new;
   logic           quiet_tail = 1'b0;
   int             cycle_count = 0;

   slot_allocator_with_payload_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_owner_id     (req_owner_id),
      .req_belongings   (req_belongings),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_owner_out    (rsp_owner_out),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_slot_is_free (rsp_slot_is_free)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // response side hold-off bursts
   initial begin : hold_off_responses
      forever begin
         repeat ($urandom_range(1, 24)) begin
            @(posedge clock);
            rsp_stall <= 1'b0;
         end
         if (!quiet_tail) begin
            repeat ($urandom_range(1, 14)) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word({rsp_status, rsp_slot_out, rsp_owner_out,
                           rsp_payload_out, rsp_slot_is_free});
   end

   // optional idle burst, then one word held until accepted
   task automatic send_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] owner,
                               logic [DATA_W-1:0] pay, logic [SLOT_W-1:0] idx);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_owner_id   <= owner;
      req_belongings <= pay;
      req_slot_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(mode, owner, pay, idx);
   endtask

   initial begin : stimulus
      episode_type       episode;
      int                burst;
      int                items_sent;
      int                held;
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] owner;
      logic [SLOT_W-1:0] idx;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(MODE_QUERY, '0, '0, '0);
      send_request(MODE_RETRIEVE, '0, '0, '0);
      send_request(MODE_STORE, '0, 32'h1234_5678, '0);
      send_request(MODE_STORE, '1, '1, '1);
      send_request(MODE_STORE, 32'h0000_0001, '0, '0);
      send_request(MODE_QUERY, '0, '0, '0);
      send_request(MODE_UNUSED, '1, '1, 12'd1);
      send_request(MODE_QUERY, '0, '0, '1);
      send_request(MODE_RETRIEVE, '0, '0, SLOT_W'(NUM_SLOTS));
      send_request(MODE_UNUSED, '0, '0, SLOT_W'(NUM_SLOTS - 1));
      send_request(MODE_QUERY, '0, '0, SLOT_W'(NUM_SLOTS - 1));
      send_request(MODE_RETRIEVE, '0, '0, 12'd1);
      send_request(MODE_RETRIEVE, '0, '0, '0);
      send_request(MODE_RETRIEVE, '0, '0, '0);
      send_request(MODE_STORE, 32'h8000_0000, 32'h5555_5555, '0);
      send_request(MODE_STORE, 32'hAAAA_AAAA, 32'hAAAA_AAAA, '1);
      send_request(MODE_RETRIEVE, '0, '0, SLOT_W'(NUM_SLOTS - 1));
      send_request(MODE_UNUSED, '0, '0, '1);
      send_request(MODE_RETRIEVE, '0, '0, '0);
      send_request(MODE_STORE, '1, '0, 12'h800);

      items_sent = 0;
      episode = EP_FILL;
      while (items_sent < RANDOM_ITEMS) begin
         case (episode)
            EP_FILL:  burst = board.free_count + $urandom_range(1, 4);
            EP_DRAIN: burst = (NUM_SLOTS - board.free_count) + $urandom_range(1, 3);
            default:  burst = $urandom_range(8, 30);
         endcase
         repeat (burst) begin
            if (items_sent >= RANDOM_ITEMS) break;
            quiet_tail = (items_sent >= RANDOM_ITEMS - QUIET_ITEMS);
            owner = ($urandom_range(0, 19) == 0) ? '0 :
                    ($urandom_range(0, 19) == 0) ? '1 : DATA_W'($urandom);
            idx = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 4095)) :
                                               SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            case (episode)
               EP_FILL: mode = MODE_STORE;
               EP_DRAIN: begin
                  mode = MODE_RETRIEVE;
                  held = board.held_slot();
                  if (held >= 0 && $urandom_range(0, 9) != 0) idx = SLOT_W'(held);
               end
               default: mode = MODE_W'($urandom_range(0, 3));
            endcase
            send_request(mode, owner, DATA_W'($urandom), idx);
            items_sent++;
         end
         episode = episode_type'($urandom_range(0, 2));
      end

      req_valid <= 1'b0;
      while (board.awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("requests: %0d store, %0d query, %0d retrieve, %0d unused mode",
               board.mode_hits[MODE_STORE], board.mode_hits[MODE_QUERY],
               board.mode_hits[MODE_RETRIEVE], board.mode_hits[MODE_UNUSED]);
      $display("words: %0d ok, %0d full, %0d range, %0d already free, %0d zero owner",
               board.status_hits[ST_OK], board.status_hits[ST_FULL],
               board.status_hits[ST_RANGE], board.status_hits[ST_FREE],
               board.status_hits[ST_ZERO_OWNER]);
      if (board.mismatches == 0 && board.awaited_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/slotalloc_pkg.sv
hdl/slotalloc_ram.sv
hdl/slot_allocator_with_payload_top.sv
sim/tb_slot_allocator_with_payload_top.sv
